// ===== sv/cpu_6502_instruction_core_macros.svh =====
// Assertion macros for the 6502 instruction core checker.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef CPU_6502_INSTRUCTION_CORE_MACROS_SVH
`define CPU_6502_INSTRUCTION_CORE_MACROS_SVH

// Same-cycle implication.
`define C6502_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("c6502 check failed");

// Next-cycle implication.
`define C6502_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("c6502 check failed");

`endif

// ===== sv/c6502_pkg.sv =====
// Shared types and constants of the 6502 instruction core.
// Used by the controller, the datapath, the top level and the checker.
package c6502_pkg;

    localparam int MEM_ADDR_BITS_DEF = 16;

    localparam logic [7:0]  STACK_PAGE = 8'h01;
    localparam logic [15:0] VEC_RESET  = 16'hFFFC;
    localparam logic [15:0] VEC_BRK    = 16'hFFFE;
    localparam logic [7:0]  S_RESET    = 8'hFD;
    localparam logic [7:0]  P_RESET    = 8'h34;
    localparam logic [7:0]  P_BRK_BITS = 8'h30;
    localparam logic [7:0]  P_I_BIT    = 8'h04;

    localparam logic [1:0] FN_LOAD = 2'd0;
    localparam logic [1:0] FN_READ = 2'd1;
    localparam logic [1:0] FN_EXEC = 2'd2;
    localparam logic [1:0] FN_RST  = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] address;
        logic [7:0]  data;
    } t_in;

    typedef struct packed {
        logic [15:0] pc_value;
        logic [7:0]  a_value;
        logic [7:0]  x_value;
        logic [7:0]  y_value;
        logic [7:0]  s_value;
        logic [7:0]  p_value;
        logic [7:0]  read_data;
        logic        illegal;
    } t_out;

    // Memory address source
    typedef enum logic [2:0] {
        MA_PC, MA_TA, MA_TA1, MA_STK, MA_STK1, MA_IN
    } t_asel;

    // Memory write data source
    typedef enum logic [3:0] {
        W_A, W_X, W_Y, W_P, W_PBRK, W_PCDH, W_PCIH, W_PCL, W_IN, W_RMW
    } t_wsel;

    typedef enum logic [2:0] {
        PC_HOLD, PC_INC, PC_DEC, PC_BR, PC_QTD, PC_QTD1, PC_TA
    } t_pcop;

    typedef enum logic [2:0] {
        TA_HOLD, TA_ZP, TA_ABS, TA_VECR, TA_VECB
    } t_tasel;

    typedef enum logic [1:0] {
        IX_NONE, IX_X, IX_Y
    } t_idx;

    typedef enum logic [1:0] {
        SP_HOLD, SP_INC, SP_DEC
    } t_sop;

    typedef enum logic [5:0] {
        AL_NOP, AL_ORA, AL_AND, AL_EOR, AL_ADC, AL_SBC, AL_LDA, AL_CMP,
        AL_CPX, AL_CPY, AL_LDX, AL_LDY, AL_BIT,
        AL_ASL, AL_ROL, AL_LSR, AL_ROR, AL_INC, AL_DEC,
        AL_ASLA, AL_ROLA, AL_LSRA, AL_RORA,
        AL_TAX, AL_TXA, AL_TAY, AL_TYA, AL_TSX, AL_TXS,
        AL_INX, AL_INY, AL_DEX, AL_DEY,
        AL_CLC, AL_SEC, AL_CLI, AL_SEI, AL_CLV, AL_CLD, AL_SED,
        AL_PLP, AL_BRKP, AL_RST
    } t_alu;

    typedef struct packed {
        logic   start;
        t_asel  asel;
        logic   we;
        t_wsel  wsel;
        t_pcop  pc_op;
        t_tasel ta_sel;
        t_idx   idx;
        logic   td_ld;
        t_sop   s_op;
        logic   ex;
        t_alu   alu;
        logic   ir_ld;
        logic   rd_ld;
        logic   ill_set;
        logic   out_ld;
    } t_cmd;

    typedef struct packed {
        logic [7:0] q;
        logic [7:0] ir;
    } t_stat;

endpackage

// ===== sv/c6502_dp.sv =====
// Datapath of the 6502 instruction core: registers, ALU, address unit, memory.
// Driven by c6502_ctrl through t_cmd; depends on c6502_pkg.
module c6502_dp
    import c6502_pkg::*;
#(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_in   i_in,
    output t_stat o_stat,
    output t_out  o_out
);

    localparam int DEPTH = 1 << MEM_ADDR_BITS;

    logic [7:0] r_mem [0:DEPTH-1];
    logic [7:0] r_q;

    logic [15:0] r_pc;
    logic [7:0]  r_a, r_x, r_y, r_s, r_p;
    logic [15:0] r_ta;
    logic [7:0]  r_td, r_ir, r_rd;
    logic        r_ill;
    t_in         r_in;
    t_out        r_out;

    logic [15:0] maddr;
    logic [7:0]  wdata;
    logic [7:0]  a_nx, x_nx, y_nx, s_nx, p_nx, res;
    logic [7:0]  idx8, cmp_r, add_b, sh_v;
    logic [8:0]  sum9, diff9, sh9;
    logic [1:0]  sh_kind;

    function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
        return {v[7], p[6:2], (v == 8'h00), p[0]};
    endfunction

    // kind: ASL, ROL, LSR, ROR; returns {carry, result}
    function automatic logic [8:0] shift8(input logic [1:0] kind, input logic [7:0] v,
                                          input logic c);
        logic [8:0] r;
        case (kind)
            2'd0:    r = {v[7], v[6:0], 1'b0};
            2'd1:    r = {v[7], v[6:0], c};
            2'd2:    r = {v[0], 1'b0, v[7:1]};
            default: r = {v[0], c, v[7:1]};
        endcase
        return r;
    endfunction

    function automatic logic branch_taken(input logic [7:0] op, input logic [7:0] p);
        logic f;
        case (op[7:6])
            2'd0:    f = p[7];
            2'd1:    f = p[6];
            2'd2:    f = p[0];
            default: f = p[1];
        endcase
        return f == op[5];
    endfunction

    always_comb begin
        case (i_cmd.asel)
            MA_PC:   maddr = r_pc;
            MA_TA:   maddr = r_ta;
            MA_TA1:  maddr = r_ta + 16'd1;
            MA_STK:  maddr = {STACK_PAGE, r_s};
            MA_STK1: maddr = {STACK_PAGE, r_s + 8'd1};
            default: maddr = r_in.address;
        endcase
    end

    always_comb begin
        logic [15:0] pcd, pci;
        pcd = r_pc - 16'd1;
        pci = r_pc + 16'd1;
        case (i_cmd.wsel)
            W_A:     wdata = r_a;
            W_X:     wdata = r_x;
            W_Y:     wdata = r_y;
            W_P:     wdata = r_p;
            W_PBRK:  wdata = r_p | P_BRK_BITS;
            W_PCDH:  wdata = pcd[15:8];
            W_PCIH:  wdata = pci[15:8];
            W_PCL:   wdata = r_pc[7:0];
            W_IN:    wdata = r_in.data;
            default: wdata = res;
        endcase
    end

    // ALU
    always_comb begin
        a_nx = r_a; x_nx = r_x; y_nx = r_y; s_nx = r_s; p_nx = r_p; res = r_q;
        add_b = (i_cmd.alu == AL_SBC) ? ~r_q : r_q;
        sum9  = {1'b0, r_a} + {1'b0, add_b} + {8'd0, r_p[0]};
        case (i_cmd.alu)
            AL_CPX:  cmp_r = r_x;
            AL_CPY:  cmp_r = r_y;
            default: cmp_r = r_a;
        endcase
        diff9 = {1'b0, cmp_r} - {1'b0, r_q};
        case (i_cmd.alu)
            AL_ASL, AL_ASLA: sh_kind = 2'd0;
            AL_ROL, AL_ROLA: sh_kind = 2'd1;
            AL_LSR, AL_LSRA: sh_kind = 2'd2;
            default:         sh_kind = 2'd3;
        endcase
        sh_v = (i_cmd.alu inside {AL_ASLA, AL_ROLA, AL_LSRA, AL_RORA}) ? r_a : r_q;
        sh9  = shift8(sh_kind, sh_v, r_p[0]);
        case (i_cmd.alu)
            AL_ORA: begin a_nx = r_a | r_q; p_nx = set_nz(r_p, a_nx); end
            AL_AND: begin a_nx = r_a & r_q; p_nx = set_nz(r_p, a_nx); end
            AL_EOR: begin a_nx = r_a ^ r_q; p_nx = set_nz(r_p, a_nx); end
            AL_ADC, AL_SBC: begin
                a_nx    = sum9[7:0];
                p_nx    = set_nz(r_p, a_nx);
                p_nx[6] = ~(r_a[7] ^ add_b[7]) & (r_a[7] ^ sum9[7]);
                p_nx[0] = sum9[8];
            end
            AL_LDA: begin a_nx = r_q; p_nx = set_nz(r_p, r_q); end
            AL_LDX: begin x_nx = r_q; p_nx = set_nz(r_p, r_q); end
            AL_LDY: begin y_nx = r_q; p_nx = set_nz(r_p, r_q); end
            AL_CMP, AL_CPX, AL_CPY: begin
                p_nx    = set_nz(r_p, diff9[7:0]);
                p_nx[0] = ~diff9[8];
            end
            AL_BIT: begin
                p_nx    = r_p;
                p_nx[7] = r_q[7];
                p_nx[6] = r_q[6];
                p_nx[1] = ((r_a & r_q) == 8'h00);
            end
            AL_ASL, AL_ROL, AL_LSR, AL_ROR: begin
                res     = sh9[7:0];
                p_nx    = set_nz(r_p, res);
                p_nx[0] = sh9[8];
            end
            AL_ASLA, AL_ROLA, AL_LSRA, AL_RORA: begin
                a_nx    = sh9[7:0];
                p_nx    = set_nz(r_p, a_nx);
                p_nx[0] = sh9[8];
            end
            AL_INC: begin res = r_q + 8'd1; p_nx = set_nz(r_p, res); end
            AL_DEC: begin res = r_q - 8'd1; p_nx = set_nz(r_p, res); end
            AL_TAX: begin x_nx = r_a; p_nx = set_nz(r_p, r_a); end
            AL_TXA: begin a_nx = r_x; p_nx = set_nz(r_p, r_x); end
            AL_TAY: begin y_nx = r_a; p_nx = set_nz(r_p, r_a); end
            AL_TYA: begin a_nx = r_y; p_nx = set_nz(r_p, r_y); end
            AL_TSX: begin x_nx = r_s; p_nx = set_nz(r_p, r_s); end
            AL_TXS: s_nx = r_x;
            AL_INX: begin x_nx = r_x + 8'd1; p_nx = set_nz(r_p, x_nx); end
            AL_INY: begin y_nx = r_y + 8'd1; p_nx = set_nz(r_p, y_nx); end
            AL_DEX: begin x_nx = r_x - 8'd1; p_nx = set_nz(r_p, x_nx); end
            AL_DEY: begin y_nx = r_y - 8'd1; p_nx = set_nz(r_p, y_nx); end
            AL_CLC: p_nx[0] = 1'b0;
            AL_SEC: p_nx[0] = 1'b1;
            AL_CLI: p_nx[2] = 1'b0;
            AL_SEI: p_nx[2] = 1'b1;
            AL_CLV: p_nx[6] = 1'b0;
            AL_CLD: p_nx[3] = 1'b0;
            AL_SED: p_nx[3] = 1'b1;
            AL_PLP: p_nx = r_q;
            AL_BRKP: p_nx = r_p | P_BRK_BITS;
            AL_RST: begin s_nx = r_s - 8'd3; p_nx = r_p | P_I_BIT; end
            default: ;
        endcase
    end

    always_comb begin
        case (i_cmd.idx)
            IX_X:    idx8 = r_x;
            IX_Y:    idx8 = r_y;
            default: idx8 = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= 16'h0000;
            r_a  <= 8'h00;
            r_x  <= 8'h00;
            r_y  <= 8'h00;
            r_s  <= S_RESET;
            r_p  <= P_RESET;
        end else begin
            if (i_cmd.ex) begin
                r_a <= a_nx;
                r_x <= x_nx;
                r_y <= y_nx;
                r_p <= p_nx;
            end
            case (i_cmd.s_op)
                SP_INC:  r_s <= r_s + 8'd1;
                SP_DEC:  r_s <= r_s - 8'd1;
                default: if (i_cmd.ex) r_s <= s_nx;
            endcase
            case (i_cmd.pc_op)
                PC_INC:  r_pc <= r_pc + 16'd1;
                PC_DEC:  r_pc <= r_pc - 16'd1;
                PC_BR:   if (branch_taken(r_ir, r_p)) r_pc <= r_pc + {{8{r_q[7]}}, r_q};
                PC_QTD:  r_pc <= {r_q, r_td};
                PC_QTD1: r_pc <= {r_q, r_td} + 16'd1;
                PC_TA:   r_pc <= r_ta;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.ta_sel)
            TA_ZP:   r_ta <= {8'h00, r_q + idx8};
            TA_ABS:  r_ta <= {r_q, r_td} + {8'h00, idx8};
            TA_VECR: r_ta <= VEC_RESET;
            TA_VECB: r_ta <= VEC_BRK;
            default: ;
        endcase
        if (i_cmd.td_ld) r_td <= r_q;
        if (i_cmd.ir_ld) r_ir <= r_q;
        if (i_cmd.start) begin
            r_in  <= i_in;
            r_rd  <= 8'h00;
            r_ill <= 1'b0;
        end else begin
            if (i_cmd.rd_ld) r_rd <= r_q;
            if (i_cmd.ill_set) r_ill <= 1'b1;
        end
        if (i_cmd.out_ld) begin
            r_out.pc_value  <= r_pc;
            r_out.a_value   <= r_a;
            r_out.x_value   <= r_x;
            r_out.y_value   <= r_y;
            r_out.s_value   <= r_s;
            r_out.p_value   <= r_p;
            r_out.read_data <= r_rd;
            r_out.illegal   <= r_ill;
        end
    end

    // single-port byte memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) r_mem[maddr[MEM_ADDR_BITS-1:0]] <= wdata;
        r_q <= r_mem[maddr[MEM_ADDR_BITS-1:0]];
    end

    assign o_stat.q  = r_q;
    assign o_stat.ir = r_ir;
    assign o_out     = r_out;

endmodule

// ===== sv/c6502_ctrl.sv =====
// Controller of the 6502 instruction core: opcode decode and access sequencer.
// Issues t_cmd to c6502_dp and reads back t_stat; depends on c6502_pkg.
module c6502_ctrl
    import c6502_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    output logic       o_in_stall,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX, M_ABSY, M_XIND, M_INDY,
        M_REL, M_JMP, M_JMPI, M_JSR, M_RTS, M_RTI, M_BRK, M_PUSH, M_PULL
    } t_mode;

    typedef enum logic [1:0] { K_NONE, K_READ, K_STORE, K_RMW } t_kind;

    typedef struct packed {
        logic  legal;
        t_mode mode;
        t_kind kind;
        t_alu  alu;
        t_wsel wsrc;
    } t_dec;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD, ST_READ, ST_RDCAP, ST_RST, ST_FETCH, ST_DECODE, ST_OPRD,
        ST_OP1, ST_AB2, ST_PTRA, ST_PTR1, ST_PTR2, ST_EA, ST_MEMQ, ST_PUSH,
        ST_JSR1, ST_JSR2, ST_BRK1, ST_BRK2, ST_BRK3, ST_POPA, ST_POP1, ST_RTS2,
        ST_RTI2, ST_RTI3, ST_DONE
    } t_state;

    localparam logic [7:0] OP_BRK = 8'h00, OP_PHP = 8'h08, OP_PLP = 8'h28;
    localparam logic [7:0] OP_PHA = 8'h48, OP_PLA = 8'h68, OP_CLC = 8'h18;
    localparam logic [7:0] OP_SEC = 8'h38, OP_CLI = 8'h58, OP_SEI = 8'h78;
    localparam logic [7:0] OP_CLV = 8'hB8, OP_CLD = 8'hD8, OP_SED = 8'hF8;
    localparam logic [7:0] OP_JSR = 8'h20, OP_RTI = 8'h40, OP_RTS = 8'h60;
    localparam logic [7:0] OP_JMP = 8'h4C, OP_JMPI = 8'h6C;
    localparam logic [7:0] OP_BITZ = 8'h24, OP_BITA = 8'h2C;
    localparam logic [7:0] OP_STYZ = 8'h84, OP_STYA = 8'h8C, OP_STYZX = 8'h94;
    localparam logic [7:0] OP_DEY = 8'h88, OP_INY = 8'hC8, OP_INX = 8'hE8;
    localparam logic [7:0] OP_TYA = 8'h98, OP_TAY = 8'hA8;
    localparam logic [7:0] OP_LDYI = 8'hA0, OP_LDYZ = 8'hA4, OP_LDYA = 8'hAC;
    localparam logic [7:0] OP_LDYZX = 8'hB4, OP_LDYAX = 8'hBC;
    localparam logic [7:0] OP_CPYI = 8'hC0, OP_CPYZ = 8'hC4, OP_CPYA = 8'hCC;
    localparam logic [7:0] OP_CPXI = 8'hE0, OP_CPXZ = 8'hE4, OP_CPXA = 8'hEC;
    localparam logic [7:0] OP_STAI = 8'h89, OP_TXS = 8'h9A, OP_TSX = 8'hBA;
    localparam logic [7:0] OP_LDXI = 8'hA2, OP_SHXAY = 8'h9E;

    localparam logic [1:0] GRP0 = 2'b00, GRP1 = 2'b01, GRP2 = 2'b10;
    localparam logic [2:0] AAA_ST = 3'd4, AAA_LD = 3'd5;

    function automatic t_dec decode(input logic [7:0] op);
        t_dec d;
        logic [2:0] aaa, bbb;
        aaa = op[7:5];
        bbb = op[4:2];
        d.legal = 1'b1; d.mode = M_IMP; d.kind = K_NONE; d.alu = AL_NOP; d.wsrc = W_A;
        case (op[1:0])
            GRP1: begin
                case (bbb)
                    3'd0:    d.mode = M_XIND;
                    3'd1:    d.mode = M_ZP;
                    3'd2:    d.mode = M_IMM;
                    3'd3:    d.mode = M_ABS;
                    3'd4:    d.mode = M_INDY;
                    3'd5:    d.mode = M_ZPX;
                    3'd6:    d.mode = M_ABSY;
                    default: d.mode = M_ABSX;
                endcase
                if (aaa == AAA_ST) begin
                    d.kind  = K_STORE;
                    d.legal = (op != OP_STAI);
                end else begin
                    d.kind = K_READ;
                    case (aaa)
                        3'd0:    d.alu = AL_ORA;
                        3'd1:    d.alu = AL_AND;
                        3'd2:    d.alu = AL_EOR;
                        3'd3:    d.alu = AL_ADC;
                        3'd5:    d.alu = AL_LDA;
                        3'd6:    d.alu = AL_CMP;
                        default: d.alu = AL_SBC;
                    endcase
                end
            end
            GRP2: begin
                if (bbb == 3'd2) begin
                    case (aaa)
                        3'd0:    d.alu = AL_ASLA;
                        3'd1:    d.alu = AL_ROLA;
                        3'd2:    d.alu = AL_LSRA;
                        3'd3:    d.alu = AL_RORA;
                        3'd4:    d.alu = AL_TXA;
                        3'd5:    d.alu = AL_TAX;
                        3'd6:    d.alu = AL_DEX;
                        default: d.alu = AL_NOP;
                    endcase
                end else if (bbb == 3'd6) begin
                    if (op == OP_TXS) d.alu = AL_TXS;
                    else if (op == OP_TSX) d.alu = AL_TSX;
                    else d.legal = 1'b0;
                end else if (bbb == 3'd4) begin
                    d.legal = 1'b0;
                end else if (bbb == 3'd0) begin
                    d.mode  = M_IMM;
                    d.kind  = K_READ;
                    d.alu   = AL_LDX;
                    d.legal = (op == OP_LDXI);
                end else begin
                    d.legal = (op != OP_SHXAY);
                    case (bbb)
                        3'd1:    d.mode = M_ZP;
                        3'd3:    d.mode = M_ABS;
                        3'd5:    d.mode = (aaa == AAA_ST || aaa == AAA_LD) ? M_ZPY : M_ZPX;
                        default: d.mode = (aaa == AAA_LD) ? M_ABSY : M_ABSX;
                    endcase
                    d.kind = K_RMW;
                    case (aaa)
                        3'd0: d.alu = AL_ASL;
                        3'd1: d.alu = AL_ROL;
                        3'd2: d.alu = AL_LSR;
                        3'd3: d.alu = AL_ROR;
                        3'd4: begin d.kind = K_STORE; d.wsrc = W_X; end
                        3'd5: begin d.kind = K_READ; d.alu = AL_LDX; end
                        3'd6: d.alu = AL_DEC;
                        default: d.alu = AL_INC;
                    endcase
                end
            end
            GRP0: begin
                if (op[4:0] == 5'h10) begin
                    d.mode = M_REL;
                end else begin
                    case (op)
                        OP_BRK:   d.mode = M_BRK;
                        OP_PHP:   begin d.mode = M_PUSH; d.wsrc = W_P; end
                        OP_PHA:   d.mode = M_PUSH;
                        OP_PLP:   begin d.mode = M_PULL; d.alu = AL_PLP; end
                        OP_PLA:   begin d.mode = M_PULL; d.alu = AL_LDA; end
                        OP_CLC:   d.alu = AL_CLC;
                        OP_SEC:   d.alu = AL_SEC;
                        OP_CLI:   d.alu = AL_CLI;
                        OP_SEI:   d.alu = AL_SEI;
                        OP_CLV:   d.alu = AL_CLV;
                        OP_CLD:   d.alu = AL_CLD;
                        OP_SED:   d.alu = AL_SED;
                        OP_JSR:   d.mode = M_JSR;
                        OP_RTI:   d.mode = M_RTI;
                        OP_RTS:   d.mode = M_RTS;
                        OP_JMP:   d.mode = M_JMP;
                        OP_JMPI:  d.mode = M_JMPI;
                        OP_BITZ:  begin d.mode = M_ZP;  d.kind = K_READ; d.alu = AL_BIT; end
                        OP_BITA:  begin d.mode = M_ABS; d.kind = K_READ; d.alu = AL_BIT; end
                        OP_STYZ:  begin d.mode = M_ZP;  d.kind = K_STORE; d.wsrc = W_Y; end
                        OP_STYA:  begin d.mode = M_ABS; d.kind = K_STORE; d.wsrc = W_Y; end
                        OP_STYZX: begin d.mode = M_ZPX; d.kind = K_STORE; d.wsrc = W_Y; end
                        OP_DEY:   d.alu = AL_DEY;
                        OP_INY:   d.alu = AL_INY;
                        OP_INX:   d.alu = AL_INX;
                        OP_TYA:   d.alu = AL_TYA;
                        OP_TAY:   d.alu = AL_TAY;
                        OP_LDYI:  begin d.mode = M_IMM;  d.kind = K_READ; d.alu = AL_LDY; end
                        OP_LDYZ:  begin d.mode = M_ZP;   d.kind = K_READ; d.alu = AL_LDY; end
                        OP_LDYA:  begin d.mode = M_ABS;  d.kind = K_READ; d.alu = AL_LDY; end
                        OP_LDYZX: begin d.mode = M_ZPX;  d.kind = K_READ; d.alu = AL_LDY; end
                        OP_LDYAX: begin d.mode = M_ABSX; d.kind = K_READ; d.alu = AL_LDY; end
                        OP_CPYI:  begin d.mode = M_IMM;  d.kind = K_READ; d.alu = AL_CPY; end
                        OP_CPYZ:  begin d.mode = M_ZP;   d.kind = K_READ; d.alu = AL_CPY; end
                        OP_CPYA:  begin d.mode = M_ABS;  d.kind = K_READ; d.alu = AL_CPY; end
                        OP_CPXI:  begin d.mode = M_IMM;  d.kind = K_READ; d.alu = AL_CPX; end
                        OP_CPXZ:  begin d.mode = M_ZP;   d.kind = K_READ; d.alu = AL_CPX; end
                        OP_CPXA:  begin d.mode = M_ABS;  d.kind = K_READ; d.alu = AL_CPX; end
                        default:  d.legal = 1'b0;
                    endcase
                end
            end
            default: d.legal = 1'b0;
        endcase
        return d;
    endfunction

    t_state r_state, n_state;
    logic   r_vec, n_vec;
    logic   r_ovalid, n_ovalid;
    t_dec   d_q, d_ir;
    t_cmd   cmd;

    assign d_q  = decode(i_stat.q);
    assign d_ir = decode(i_stat.ir);

    always_comb begin
        cmd      = '0;
        n_state  = r_state;
        n_vec    = r_vec;
        n_ovalid = r_ovalid && i_out_stall;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.start = 1'b1;
                    n_vec     = 1'b0;
                    case (i_func)
                        FN_LOAD: n_state = ST_LOAD;
                        FN_READ: n_state = ST_READ;
                        FN_EXEC: n_state = ST_FETCH;
                        default: n_state = ST_RST;
                    endcase
                end
            end
            ST_LOAD: begin
                cmd.asel = MA_IN; cmd.we = 1'b1; cmd.wsel = W_IN;
                n_state  = ST_DONE;
            end
            ST_READ: begin
                cmd.asel = MA_IN;
                n_state  = ST_RDCAP;
            end
            ST_RDCAP: begin
                cmd.rd_ld = 1'b1;
                n_state   = ST_DONE;
            end
            ST_RST: begin
                cmd.ex = 1'b1; cmd.alu = AL_RST; cmd.ta_sel = TA_VECR;
                n_vec   = 1'b1;
                n_state = ST_PTRA;
            end
            ST_FETCH: begin
                cmd.asel = MA_PC;
                n_state  = ST_DECODE;
            end
            ST_DECODE: begin
                cmd.ir_ld = 1'b1;
                if (!d_q.legal) begin
                    // leave A, X, Y, S, P and PC as they were; only IR and the illegal flag load
                    cmd.ill_set = 1'b1;
                    n_state     = ST_DONE;
                end else begin
                    cmd.pc_op = PC_INC;
                    case (d_q.mode)
                        M_IMP: begin
                            cmd.ex = 1'b1; cmd.alu = d_q.alu;
                            n_state = ST_DONE;
                        end
                        M_PUSH:               n_state = ST_PUSH;
                        M_PULL, M_RTS, M_RTI: n_state = ST_POPA;
                        M_BRK:                n_state = ST_BRK1;
                        default:              n_state = ST_OPRD;
                    endcase
                end
            end
            ST_OPRD: begin
                cmd.asel = MA_PC; cmd.pc_op = PC_INC;
                n_state  = ST_OP1;
            end
            ST_OP1: begin
                case (d_ir.mode)
                    M_IMM: begin
                        cmd.ex = 1'b1; cmd.alu = d_ir.alu;
                        n_state = ST_DONE;
                    end
                    M_ZP:  begin cmd.ta_sel = TA_ZP; n_state = ST_EA; end
                    M_ZPX: begin cmd.ta_sel = TA_ZP; cmd.idx = IX_X; n_state = ST_EA; end
                    M_ZPY: begin cmd.ta_sel = TA_ZP; cmd.idx = IX_Y; n_state = ST_EA; end
                    M_REL: begin cmd.pc_op = PC_BR; n_state = ST_DONE; end
                    M_XIND: begin
                        cmd.ta_sel = TA_ZP; cmd.idx = IX_X;
                        n_state = ST_PTRA;
                    end
                    M_INDY: begin cmd.ta_sel = TA_ZP; n_state = ST_PTRA; end
                    default: begin
                        cmd.td_ld = 1'b1; cmd.asel = MA_PC; cmd.pc_op = PC_INC;
                        n_state = ST_AB2;
                    end
                endcase
            end
            ST_AB2: begin
                cmd.ta_sel = TA_ABS;
                case (d_ir.mode)
                    M_ABSX: begin cmd.idx = IX_X; n_state = ST_EA; end
                    M_ABSY: begin cmd.idx = IX_Y; n_state = ST_EA; end
                    M_JMP: begin
                        cmd.ta_sel = TA_HOLD; cmd.pc_op = PC_QTD;
                        n_state = ST_DONE;
                    end
                    M_JMPI: begin n_vec = 1'b1; n_state = ST_PTRA; end
                    M_JSR:  n_state = ST_JSR1;
                    default: n_state = ST_EA;
                endcase
            end
            ST_PTRA: begin
                cmd.asel = MA_TA;
                n_state  = ST_PTR1;
            end
            ST_PTR1: begin
                cmd.td_ld = 1'b1; cmd.asel = MA_TA1;
                n_state   = ST_PTR2;
            end
            ST_PTR2: begin
                if (r_vec) begin
                    cmd.pc_op = PC_QTD;
                    n_state   = ST_DONE;
                end else begin
                    cmd.ta_sel = TA_ABS;
                    cmd.idx    = (d_ir.mode == M_INDY) ? IX_Y : IX_NONE;
                    n_state    = ST_EA;
                end
            end
            ST_EA: begin
                cmd.asel = MA_TA;
                if (d_ir.kind == K_STORE) begin
                    cmd.we = 1'b1; cmd.wsel = d_ir.wsrc;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MEMQ;
                end
            end
            ST_MEMQ: begin
                cmd.ex = 1'b1; cmd.alu = d_ir.alu;
                if (d_ir.kind == K_RMW) begin
                    cmd.asel = MA_TA; cmd.we = 1'b1; cmd.wsel = W_RMW;
                end
                n_state = ST_DONE;
            end
            ST_PUSH: begin
                cmd.asel = MA_STK; cmd.we = 1'b1; cmd.wsel = d_ir.wsrc; cmd.s_op = SP_DEC;
                n_state  = ST_DONE;
            end
            ST_JSR1: begin
                cmd.asel = MA_STK; cmd.we = 1'b1; cmd.wsel = W_PCDH; cmd.s_op = SP_DEC;
                cmd.pc_op = PC_DEC;
                n_state  = ST_JSR2;
            end
            ST_JSR2: begin
                cmd.asel = MA_STK; cmd.we = 1'b1; cmd.wsel = W_PCL; cmd.s_op = SP_DEC;
                cmd.pc_op = PC_TA;
                n_state  = ST_DONE;
            end
            ST_BRK1: begin
                cmd.asel = MA_STK; cmd.we = 1'b1; cmd.wsel = W_PCIH; cmd.s_op = SP_DEC;
                cmd.pc_op = PC_INC;
                n_state  = ST_BRK2;
            end
            ST_BRK2: begin
                cmd.asel = MA_STK; cmd.we = 1'b1; cmd.wsel = W_PCL; cmd.s_op = SP_DEC;
                n_state  = ST_BRK3;
            end
            ST_BRK3: begin
                cmd.asel = MA_STK; cmd.we = 1'b1; cmd.wsel = W_PBRK; cmd.s_op = SP_DEC;
                cmd.ex = 1'b1; cmd.alu = AL_BRKP; cmd.ta_sel = TA_VECB;
                n_vec   = 1'b1;
                n_state = ST_PTRA;
            end
            ST_POPA: begin
                cmd.asel = MA_STK1; cmd.s_op = SP_INC;
                n_state  = ST_POP1;
            end
            ST_POP1: begin
                case (d_ir.mode)
                    M_PULL: begin
                        cmd.ex = 1'b1; cmd.alu = d_ir.alu;
                        n_state = ST_DONE;
                    end
                    M_RTS: begin
                        cmd.td_ld = 1'b1; cmd.asel = MA_STK1; cmd.s_op = SP_INC;
                        n_state = ST_RTS2;
                    end
                    default: begin
                        cmd.ex = 1'b1; cmd.alu = AL_PLP;
                        cmd.asel = MA_STK1; cmd.s_op = SP_INC;
                        n_state = ST_RTI2;
                    end
                endcase
            end
            ST_RTS2: begin
                cmd.pc_op = PC_QTD1;
                n_state   = ST_DONE;
            end
            ST_RTI2: begin
                cmd.td_ld = 1'b1; cmd.asel = MA_STK1; cmd.s_op = SP_INC;
                n_state   = ST_RTI3;
            end
            ST_RTI3: begin
                cmd.pc_op = PC_QTD;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_ovalid || !i_out_stall) begin
                    cmd.out_ld = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_vec    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_vec    <= n_vec;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

// ===== sv/cpu_6502_instruction_core.sv =====
// 6502 instruction core (binary arithmetic only) with a byte memory.
// Input channel: i_in_valid / o_in_stall carry t_in {func, address, data}.
//   func selects: write a memory byte, read a memory byte, execute one
//   instruction at PC, or run the reset sequence.
// Output channel: o_out_valid / i_out_stall carry t_out with PC, A, X, Y, S, P
//   after the item, the read byte (zero unless a read) and the illegal flag.
// One item is in work at a time. The controller gives a state of its own to each
//   access to the single-port memory, besides the states for fetch and decode.
// The result sits in an output register; the next item is taken while it waits,
//   and that item's result holds in the controller until the register is freed.
// Reset (i_rst_n low, synchronous) clears PC, A, X, Y, sets S to 0xFD and P to
//   0x34, and empties the output register; memory keeps whatever it holds and
//   is undefined until written.
// Depends on c6502_pkg, c6502_ctrl and c6502_dp.
module cpu_6502_instruction_core
    import c6502_pkg::*;
#(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    c6502_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_in_data.func),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    c6502_dp #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in_data),
        .o_stat  (stat),
        .o_out   (o_out_data)
    );

endmodule

// ===== sv/c6502_chk.sv =====
// Port-level checker for the 6502 instruction core, bound to the top level.
// Depends on c6502_pkg and cpu_6502_instruction_core_macros.svh.
`include "cpu_6502_instruction_core_macros.svh"

module c6502_chk
    import c6502_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    `C6502_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `C6502_ASSERT_NXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_data))
    `C6502_ASSERT_NXT(a_busy_after_transfer, i_in_valid && !o_in_stall, o_in_stall)
    `C6502_ASSERT_IMP(a_read_or_illegal, o_out_valid && o_out_data.illegal, o_out_data.read_data == 8'h00)

endmodule

bind cpu_6502_instruction_core c6502_chk u_chk (.*);
